// ===== rtl/rfq_pkg.sv =====
// Shared types and constants of the receive frame filter queue.
`default_nettype none
package rfq_pkg;

   localparam int DEF_QUEUE_DEPTH   = 8;
   localparam int DEF_MAX_FRAME_LEN = 127;

   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int STORED_SLOT_W = 3;
   localparam int FREE_SLOTS_W  = 4;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PROMISCUOUS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_ACK    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_PAN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_SHORT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_LONG = 3'd4;

   // frame control codes
   localparam logic [2:0]  FT_DATA  = 3'd1;
   localparam logic [2:0]  FT_ACK   = 3'd2;
   localparam logic [1:0]  AM_SHORT = 2'd2;
   localparam logic [1:0]  AM_LONG  = 2'd3;
   localparam logic [15:0] BCAST_ID = 16'hffff;
   localparam logic [6:0]  MIN_FRAME_LEN = 7'd5;
   localparam logic [6:0]  CRC_BYTES = 7'd2;
   localparam logic [7:0]  LQI_MAX  = 8'd255;

   typedef enum logic [1:0] {
      OP_FRAME     = 2'd0,
      OP_DEQUEUE   = 2'd1,
      OP_CLEAR_ACK = 2'd2,
      OP_FLUSH     = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        crc_ok;
      logic [6:0]  frame_len;
      logic [2:0]  frame_type;
      logic [1:0]  dest_mode;
      logic        ack_request;
      logic [7:0]  seq_num;
      logic [15:0] dest_pan;
      logic [15:0] dest_short;
      logic [63:0] dest_long;
      logic [7:0]  lqi_raw;
      logic [7:0]  rssi_raw;
   } req_payload_type;

   typedef struct packed {
      logic                    accepted;
      logic                    send_ack;
      logic [7:0]              ack_seq;
      logic [STORED_SLOT_W-1:0] stored_slot;
      logic                    dropped_full;
      logic                    last_ack_valid;
      logic [7:0]              last_ack_seq;
      logic                    deq_valid;
      logic [6:0]              deq_len;
      logic [7:0]              deq_lqi;
      logic signed [7:0]       deq_rssi;
      logic [FREE_SLOTS_W-1:0] free_slots;
   } rsp_payload_type;

   typedef struct packed {
      logic        promiscuous;
      logic        auto_ack;
      logic [15:0] filter_pan;
      logic [15:0] filter_short_addr;
      logic [63:0] filter_long_addr;
   } cfg_type;

   // classified request handed from the front to the back
   typedef struct packed {
      op_type     op;
      logic       acc;
      logic       want_ack;
      logic       is_ack;
      logic [7:0] seq;
      logic [6:0] len;
      logic [7:0] lqi;
      logic [7:0] rssi;
   } cmd_type;

   typedef struct packed {
      logic [6:0] len;
      logic [7:0] lqi;
      logic [7:0] rssi;
   } slot_type;

endpackage
`default_nettype wire

// ===== rtl/rfq_req_if.sv =====
// Request channel interface: valid, ready and request payload.
`default_nettype none
interface rfq_req_if import rfq_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rfq_rsp_if.sv =====
// Response channel interface: valid, ready and response payload.
`default_nettype none
interface rfq_rsp_if import rfq_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rfq_csr.sv =====
// Configuration registers of the frame filter.
`default_nettype none
module rfq_csr import rfq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROMISCUOUS:  cfg_ff.promiscuous       <= csr_wdata[0];
            CSR_AUTO_ACK:     cfg_ff.auto_ack          <= csr_wdata[0];
            CSR_FILTER_PAN:   cfg_ff.filter_pan        <= csr_wdata[15:0];
            CSR_FILTER_SHORT: cfg_ff.filter_short_addr <= csr_wdata[15:0];
            CSR_FILTER_LONG:  cfg_ff.filter_long_addr  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/rfq_front.sv =====
// Front end: classify incoming requests and buffer them in a two-entry queue.
`default_nettype none
module rfq_front import rfq_pkg::*; #(
   parameter int MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   rfq_req_if.sink req_chan,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   localparam int CMDQ_DEPTH = 2;

   req_payload_type p;
   cmd_type         cls;
   cmd_type         cmdq_ff [CMDQ_DEPTH];
   logic            wr_ptr_ff;
   logic            rd_ptr_ff;
   logic [1:0]      fill_ff;
   logic [1:0]      fill_in;
   logic            push;

   assign p = req_chan.data;

   // filter decision depends only on the request and the configuration
   always_comb begin
      cls.op       = op_type'(p.req_type);
      cls.acc      = 1'b0;
      cls.want_ack = 1'b0;
      cls.is_ack   = 1'b0;
      cls.seq      = p.seq_num;
      cls.len      = (p.frame_len > 7'(MAX_FRAME_LEN)) ? 7'(MAX_FRAME_LEN) : p.frame_len;
      cls.lqi      = p.lqi_raw;
      cls.rssi     = p.rssi_raw;
      if (cfg.promiscuous) begin
         cls.acc = 1'b1;
      end else if (p.crc_ok && (p.frame_len >= MIN_FRAME_LEN)) begin
         if (p.frame_type == FT_ACK) begin
            cls.is_ack = 1'b1;
         end else if (p.frame_type == FT_DATA) begin
            if (p.dest_mode == AM_SHORT) begin
               cls.acc = ((p.dest_pan == BCAST_ID) && (p.dest_short == BCAST_ID)) ||
                         ((p.dest_pan == cfg.filter_pan) &&
                          ((p.dest_short == BCAST_ID) ||
                           (p.dest_short == cfg.filter_short_addr)));
            end else if (p.dest_mode == AM_LONG) begin
               cls.acc = (p.dest_pan == cfg.filter_pan) &&
                         (p.dest_long == cfg.filter_long_addr);
            end
            cls.want_ack = cls.acc && p.ack_request && cfg.auto_ack;
         end
      end
   end

   assign req_chan.ready = (fill_ff != 2'(CMDQ_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      case ({push, cmd_pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
      if (push) begin
         cmdq_ff[wr_ptr_ff] <= cls;
      end
   end

   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = cmdq_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ===== rtl/rfq_back.sv =====
// Back end: descriptor queue, ack tracking and the response register.
`default_nettype none
module rfq_back import rfq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   rfq_rsp_if.source rsp_chan
);

   localparam int IDX_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int FREE_W     = (CNT_W > FREE_SLOTS_W) ? CNT_W : FREE_SLOTS_W;
   localparam int SLOT_EXT_W = IDX_W + STORED_SLOT_W;

   typedef enum logic {B_RUN, B_DEQ} bstate_type;

   bstate_type      state_ff, state_in;
   logic [IDX_W-1:0] widx_ff, widx_in, widx_nxt;
   logic [IDX_W-1:0] ridx_ff, ridx_in, ridx_nxt;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            ack_seen_ff, ack_seen_in;
   logic [7:0]      ack_seq_ff, ack_seq_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   rsp_payload_type res;
   logic            make_rsp;
   logic            out_free;
   logic            mem_we;
   slot_type        mem_wdata;
   slot_type        slot_mem [QUEUE_DEPTH];
   slot_type        rdata_ff;
   logic [SLOT_EXT_W-1:0] widx_ext;
   logic [FREE_W-1:0]     free_w;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign widx_nxt = (widx_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : widx_ff + IDX_W'(1);
   assign ridx_nxt = (ridx_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : ridx_ff + IDX_W'(1);
   assign widx_ext = SLOT_EXT_W'(widx_ff);

   always_comb begin
      state_in     = state_ff;
      widx_in      = widx_ff;
      ridx_in      = ridx_ff;
      count_in     = count_ff;
      ack_seen_in  = ack_seen_ff;
      ack_seq_in   = ack_seq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = '{len: cmd.len, lqi: cmd.lqi, rssi: cmd.rssi};
      make_rsp     = 1'b0;
      res          = '0;
      unique case (state_ff)
         B_RUN: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_FRAME: begin
                     make_rsp = 1'b1;
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        res.dropped_full = 1'b1;
                     end else begin
                        if (cmd.is_ack) begin
                           ack_seen_in = 1'b1;
                           ack_seq_in  = cmd.seq;
                        end
                        if (cmd.acc) begin
                           res.accepted    = 1'b1;
                           res.stored_slot = widx_ext[STORED_SLOT_W-1:0];
                           res.send_ack    = cmd.want_ack;
                           res.ack_seq     = cmd.want_ack ? cmd.seq : 8'd0;
                           mem_we          = 1'b1;
                           widx_in         = widx_nxt;
                           count_in        = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  OP_DEQUEUE: begin
                     // enter B_DEQ so the registered slot memory read can present the entry
                     if (count_ff != '0) begin
                        state_in = B_DEQ;
                     end else begin
                        make_rsp = 1'b1;
                     end
                  end
                  OP_CLEAR_ACK: begin
                     make_rsp    = 1'b1;
                     ack_seen_in = 1'b0;
                  end
                  OP_FLUSH: begin
                     make_rsp = 1'b1;
                     widx_in  = '0;
                     ridx_in  = '0;
                     count_in = '0;
                  end
               endcase
            end
         end
         B_DEQ: begin
            if (out_free) begin
               make_rsp      = 1'b1;
               res.deq_valid = 1'b1;
               res.deq_len   = (rdata_ff.len >= CRC_BYTES) ? rdata_ff.len - CRC_BYTES
                                                           : rdata_ff.len;
               res.deq_lqi   = (rdata_ff.lqi[7:6] != 2'b00) ? LQI_MAX
                                                            : {rdata_ff.lqi[5:0], 2'b00};
               res.deq_rssi  = $signed(8'h00 - rdata_ff.rssi);
               ridx_in       = ridx_nxt;
               count_in      = count_ff - CNT_W'(1);
               state_in      = B_RUN;
            end
         end
      endcase
      free_w             = FREE_W'(QUEUE_DEPTH) - FREE_W'(count_in);
      res.free_slots     = free_w[FREE_SLOTS_W-1:0];
      res.last_ack_valid = ack_seen_in;
      res.last_ack_seq   = ack_seen_in ? ack_seq_in : 8'd0;
      if (make_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_RUN;
         widx_ff      <= '0;
         ridx_ff      <= '0;
         count_ff     <= '0;
         ack_seen_ff  <= 1'b0;
         ack_seq_ff   <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         ridx_ff      <= ridx_in;
         count_ff     <= count_in;
         ack_seen_ff  <= ack_seen_in;
         ack_seq_ff   <= ack_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[widx_ff] <= mem_wdata;
      end
      rdata_ff <= slot_mem[ridx_ff];
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/ieee802154_rx_frame_filter_queue_top.sv =====
// IEEE 802.15.4 receive frame filter: in a frame request, out a response per request, 
// with a bounded receive descriptor queue.
//
// Channels: req_chan carries one request per handshake (frame header,
// dequeue, clear ack tracking, flush); rsp_chan returns exactly one
// response per request, in order. The csr_ port writes filter settings;
// write it only while no request is in flight.
// An accepted request is registered in the request queue, then its response
// in the back end; a dequeue hit also passes the B_DEQ state, since the slot
// memory read port is registered. Throughput: one request per cycle for
// frame, clear and flush requests while the receiver takes responses; a
// dequeue hit holds the back end in B_DEQ, set by the single slot memory read.
// A two-entry request queue separates the classifier front end from the
// queue back end, so either side can hold without losing work.
// Reset: clears queue indices, fill count, ack tracking, configuration and
// both handshake stages; slot contents are not cleared.
// Receiver stall: the response register holds, the back end stops, the
// request queue fills and req_chan.ready drops once it holds two requests.
`default_nettype none
module ieee802154_rx_frame_filter_queue_top import rfq_pkg::*; #(
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
   parameter int MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   rfq_req_if.sink               req_chan,
   rfq_rsp_if.source             rsp_chan
);

   cfg_type cfg;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // configuration registers
   rfq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // classify each request and hold it until the back end is free
   rfq_front #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // advance queue state and register the response
   rfq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTH
   // an unpopped command at the head of the request queue must not change
   a_cmd_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && !cmd_pop) |=> (cmd_valid && (cmd == $past(cmd))))
      else $error("request queue head changed while held");

   // an acknowledgement is only raised for a stored frame
   a_ack_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.data.send_ack) |-> rsp_chan.data.accepted)
      else $error("send_ack without accepted frame");

   // a response is at most one of stored, dropped and dequeued
   a_exclusive_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !((rsp_chan.data.accepted && rsp_chan.data.dropped_full) ||
                           (rsp_chan.data.accepted && rsp_chan.data.deq_valid) ||
                           (rsp_chan.data.dropped_full && rsp_chan.data.deq_valid)))
      else $error("conflicting response outcome");

   // the free slot count never exceeds the queue depth
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((QUEUE_DEPTH > 15) ||
                          (rsp_chan.data.free_slots <= FREE_SLOTS_W'(QUEUE_DEPTH))))
      else $error("free slot count above queue depth");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the 802.15.4 receive filter queue: directed table, then random phases.
module testbench;
   import rfq_pkg::*;

   localparam int QDEPTH         = DEF_QUEUE_DEPTH;
   localparam int MAXLEN         = DEF_MAX_FRAME_LEN;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // frame control codes the package leaves unnamed
   localparam logic [2:0] FT_BEACON = 3'd0;
   localparam logic [2:0] FT_RSVD   = 3'd7;
   localparam logic [1:0] AM_NONE   = 2'd0;
   localparam logic [1:0] AM_RSVD   = 2'd1;

   typedef enum {RDY_OPEN, RDY_CHOPPY, RDY_SHUT} ready_mode_type;

   typedef struct {
      bit                   on;
      rsp_payload_type      rsp;
   } typed_rsp_type;

   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [63:0]          csr_val;
      int                   reps;
      req_payload_type      req;
      typed_rsp_type        typed;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rfq_req_if req_bus ();
   rfq_rsp_if rsp_bus ();

   ieee802154_rx_frame_filter_queue_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // Filter settings and queue state as the block should hold them.
   cfg_type     settings;
   int          q_wr;
   int          q_rd;
   int          q_count;
   logic        ack_seen_m;
   logic [7:0]  ack_seq_m;
   logic [6:0]  slot_len_m  [QDEPTH];
   logic [7:0]  slot_lqi_m  [QDEPTH];
   logic [7:0]  slot_rssi_m [QDEPTH];

   rsp_payload_type pending_rsp_q [$];   // responses owed by the block, oldest first
   typed_rsp_type   typed_rsp_q   [$];   // literal expectation per request in flight
   stim_row_type    stim_table    [$];

   int req_sent;
   int rsp_seen;
   int error_count;
   int burst_left;
   int quiet_cycles;
   int ready_left;
   ready_mode_type ready_mode;

   logic [CSR_IDX_W-1:0] csr_regs [5] = '{CSR_PROMISCUOUS, CSR_AUTO_ACK, CSR_FILTER_PAN,
                                          CSR_FILTER_SHORT, CSR_FILTER_LONG};
   int csr_widths [5] = '{1, 1, 16, 16, 64};
   int deq_mix [4] = '{8, 25, 45, 70};

   // Free-running clock, period 20.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run one request through the filter and queue; return the response it must produce.
   function automatic rsp_payload_type frame_filter_step(input req_payload_type p);
      rsp_payload_type r;
      logic            acc;
      logic            want_ack;
      logic [6:0]      len;
      int              lqi4;
      r        = '0;
      acc      = 1'b0;
      want_ack = 1'b0;
      case (p.req_type)
         OP_FRAME: begin
            if (q_count >= QDEPTH) begin
               // full queue: ignore the frame entirely, ack tracking included
               r.dropped_full = 1'b1;
            end else begin
               if (settings.promiscuous) begin
                  acc = 1'b1;
               end else if (p.crc_ok && p.frame_len >= MIN_FRAME_LEN) begin
                  if (p.frame_type == FT_ACK) begin
                     ack_seen_m = 1'b1;
                     ack_seq_m  = p.seq_num;
                  end else if (p.frame_type == FT_DATA) begin
                     if (p.dest_mode == AM_SHORT) begin
                        acc = (p.dest_pan == BCAST_ID && p.dest_short == BCAST_ID) ||
                              (p.dest_pan == settings.filter_pan &&
                               (p.dest_short == BCAST_ID ||
                                p.dest_short == settings.filter_short_addr));
                     end else if (p.dest_mode == AM_LONG) begin
                        acc = p.dest_pan == settings.filter_pan &&
                              p.dest_long == settings.filter_long_addr;
                     end
                     want_ack = p.ack_request && settings.auto_ack;
                  end
               end
               if (acc) begin
                  r.accepted    = 1'b1;
                  r.stored_slot = STORED_SLOT_W'(q_wr);
                  if (want_ack) begin
                     r.send_ack = 1'b1;
                     r.ack_seq  = p.seq_num;
                  end
                  slot_len_m[q_wr]  = (int'(p.frame_len) > MAXLEN) ? 7'(MAXLEN) : p.frame_len;
                  slot_lqi_m[q_wr]  = p.lqi_raw;
                  slot_rssi_m[q_wr] = p.rssi_raw;
                  q_wr              = (q_wr + 1) % QDEPTH;
                  q_count++;
               end
            end
         end
         OP_DEQUEUE: begin
            if (q_count > 0) begin
               len = slot_len_m[q_rd];
               if (len >= CRC_BYTES) len = len - CRC_BYTES;
               lqi4        = int'(slot_lqi_m[q_rd]) * 4;
               r.deq_valid = 1'b1;
               r.deq_len   = len;
               r.deq_lqi   = (lqi4 > int'(LQI_MAX)) ? LQI_MAX : 8'(lqi4);
               r.deq_rssi  = 8'd0 - slot_rssi_m[q_rd];
               q_rd        = (q_rd + 1) % QDEPTH;
               q_count--;
            end
         end
         OP_CLEAR_ACK: begin
            ack_seen_m = 1'b0;
         end
         OP_FLUSH: begin
            // slot contents survive a flush
            q_wr    = 0;
            q_rd    = 0;
            q_count = 0;
         end
      endcase
      r.last_ack_valid = ack_seen_m;
      r.last_ack_seq   = ack_seen_m ? ack_seq_m : 8'd0;
      r.free_slots     = FREE_SLOTS_W'(QDEPTH - q_count);
      return r;
   endfunction

   // Directed table builders.
   function automatic void add_frame(input bit crc, input logic [6:0] len,
                                     input logic [2:0] ft, input logic [1:0] dm,
                                     input bit ackreq, input logic [7:0] seq,
                                     input logic [15:0] pan, input logic [15:0] dshort,
                                     input logic [63:0] dlong, input logic [7:0] lqi,
                                     input logic [7:0] rssi, input int reps = 1);
      stim_row_type row;
      row                 = '{default: '0};
      row.reps            = reps;
      row.req.req_type    = OP_FRAME;
      row.req.crc_ok      = crc;
      row.req.frame_len   = len;
      row.req.frame_type  = ft;
      row.req.dest_mode   = dm;
      row.req.ack_request = ackreq;
      row.req.seq_num     = seq;
      row.req.dest_pan    = pan;
      row.req.dest_short  = dshort;
      row.req.dest_long   = dlong;
      row.req.lqi_raw     = lqi;
      row.req.rssi_raw    = rssi;
      stim_table.push_back(row);
   endfunction

   function automatic void add_op(input op_type op, input int reps = 1);
      stim_row_type row;
      row              = '{default: '0};
      row.reps         = reps;
      row.req.req_type = op;
      // fill the unused fields so they do not sit at zero
      row.req.seq_num  = 8'h5c;
      row.req.dest_pan = 16'hffff;
      stim_table.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      stim_row_type row;
      row         = '{default: '0};
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      stim_table.push_back(row);
   endfunction

   // Type in the expectation of the last row: nothing happens but free count and drop flag.
   function automatic void expect_quiet(input logic [3:0] free, input bit dropped);
      stim_table[stim_table.size()-1].typed.on                  = 1'b1;
      stim_table[stim_table.size()-1].typed.rsp                 = '0;
      stim_table[stim_table.size()-1].typed.rsp.free_slots      = free;
      stim_table[stim_table.size()-1].typed.rsp.dropped_full    = dropped;
   endfunction

   function automatic logic [63:0] pick_setting(input int width, input int phase);
      logic [63:0] mask;
      logic [63:0] raw;
      int          sel;
      mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
      raw  = {$urandom, $urandom};
      // first phase all zero, second all ones, then a mix of extremes and random values
      sel  = (phase < 2) ? phase : $urandom_range(0, 3);
      case (sel)
         0:       return 64'd0;
         1:       return mask;
         default: return raw & mask;
      endcase
   endfunction

   // Mostly well-formed frames aimed at the current addresses, some noise.
   function automatic req_payload_type random_request(input int deq_pct);
      logic [159:0]    noise;
      req_payload_type p;
      int              roll;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      p     = noise[$bits(req_payload_type)-1:0];
      if ($urandom_range(0, 99) < 10) return p;
      roll = $urandom_range(0, 99);
      if (roll < deq_pct) begin
         p.req_type = OP_DEQUEUE;
      end else if (roll < deq_pct + 4) begin
         p.req_type = OP_CLEAR_ACK;
      end else if (roll < deq_pct + 6) begin
         p.req_type = OP_FLUSH;
      end else begin
         p.req_type  = OP_FRAME;
         p.crc_ok    = ($urandom_range(0, 19) != 0);
         p.frame_len = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 4))
                                                   : 7'($urandom_range(5, 127));
         roll = $urandom_range(0, 9);
         if (roll < 6) p.frame_type = FT_DATA;
         else if (roll < 8) p.frame_type = FT_ACK;
         roll = $urandom_range(0, 9);
         if (roll < 5) p.dest_mode = AM_SHORT;
         else if (roll < 9) p.dest_mode = AM_LONG;
         roll = $urandom_range(0, 9);
         if (roll < 7) p.dest_pan = settings.filter_pan;
         else if (roll < 8) p.dest_pan = BCAST_ID;
         roll = $urandom_range(0, 9);
         if (roll < 4) p.dest_short = settings.filter_short_addr;
         else if (roll < 7) p.dest_short = BCAST_ID;
         roll = $urandom_range(0, 9);
         if (roll < 7) p.dest_long = settings.filter_long_addr;
         else if (roll < 8) p.dest_long = settings.filter_long_addr ^ (64'd1 << $urandom_range(0, 63));
         // keep LQI near the saturation point half the time
         if ($urandom_range(0, 1)) p.lqi_raw = 8'($urandom_range(0, 70));
      end
      return p;
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_request(input req_payload_type p, input typed_rsp_type typed);
      typed_rsp_q.push_back(typed);
      req_bus.valid <= 1'b1;
      req_bus.data  <= p;
      do @(posedge clock); while (!req_bus.ready);
      req_sent++;
   endtask

   // Close a burst now and then and idle for a random gap.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // Drop valid, wait for every owed response, then let the pipeline settle.
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (rsp_seen != req_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_PROMISCUOUS:  settings.promiscuous       = val[0];
         CSR_AUTO_ACK:     settings.auto_ack          = val[0];
         CSR_FILTER_PAN:   settings.filter_pan        = val[15:0];
         CSR_FILTER_SHORT: settings.filter_short_addr = val[15:0];
         CSR_FILTER_LONG:  settings.filter_long_addr  = val;
         default: ;
      endcase
   endtask

   task automatic check_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
         error_count++;
      end
   endtask

   task automatic compare_response(input rsp_payload_type want, input rsp_payload_type got);
      check_field("accepted",       want.accepted,       got.accepted);
      check_field("send_ack",       want.send_ack,       got.send_ack);
      check_field("ack_seq",        want.ack_seq,        got.ack_seq);
      check_field("stored_slot",    want.stored_slot,    got.stored_slot);
      check_field("dropped_full",   want.dropped_full,   got.dropped_full);
      check_field("last_ack_valid", want.last_ack_valid, got.last_ack_valid);
      check_field("last_ack_seq",   want.last_ack_seq,   got.last_ack_seq);
      check_field("deq_valid",      want.deq_valid,      got.deq_valid);
      check_field("deq_len",        want.deq_len,        got.deq_len);
      check_field("deq_lqi",        want.deq_lqi,        got.deq_lqi);
      check_field("deq_rssi",       want.deq_rssi,       got.deq_rssi);
      check_field("free_slots",     want.free_slots,     got.free_slots);
   endtask

   // Predict at every accepted request; check every accepted response against the oldest.
   always @(posedge clock) begin
      typed_rsp_type   typed;
      rsp_payload_type owed;
      if (!reset && req_bus.valid && req_bus.ready) begin
         typed = typed_rsp_q.pop_front();
         owed  = frame_filter_step(req_bus.data);
         // a typed-in row overrides the prediction; state still advances above
         if (typed.on) owed = typed.rsp;
         pending_rsp_q.push_back(owed);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen++;
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: response with no request outstanding: expected none, actual %0h",
                     $time, rsp_bus.data);
            error_count++;
         end else begin
            owed = pending_rsp_q.pop_front();
            compare_response(owed, rsp_bus.data);
         end
      end
   end

   // Receiver: alternate open stretches, choppy stretches and stalls of varied length.
   always @(posedge clock) begin
      int pick;
      if (ready_left == 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            ready_mode = RDY_OPEN;
            ready_left = $urandom_range(1, 60);
         end else if (pick < 7) begin
            ready_mode = RDY_CHOPPY;
            ready_left = $urandom_range(1, 30);
         end else if (pick < 9) begin
            ready_mode = RDY_SHUT;
            ready_left = $urandom_range(1, 8);
         end else begin
            ready_mode = RDY_SHUT;
            ready_left = $urandom_range(20, 40);
         end
      end
      ready_left--;
      case (ready_mode)
         RDY_OPEN:   rsp_bus.ready <= 1'b1;
         RDY_CHOPPY: rsp_bus.ready <= 1'($urandom_range(0, 1));
         default:    rsp_bus.ready <= 1'b0;
      endcase
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** ieee802154_rx_frame_filter_queue_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase;
      int deq_pct;
      int n_items;
      int random_sent;
      int i;
      int j;

      // Drive every input to a known value before the first edge.
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      ready_left    = 0;
      ready_mode    = RDY_OPEN;
      quiet_cycles  = 0;
      req_sent      = 0;
      rsp_seen      = 0;
      error_count   = 0;
      random_sent   = 0;

      // Model state after reset; slots start at zero but are never read unwritten.
      settings   = '0;
      q_wr       = 0;
      q_rd       = 0;
      q_count    = 0;
      ack_seen_m = 1'b0;
      ack_seq_m  = 8'd0;
      for (i = 0; i < QDEPTH; i++) begin
         slot_len_m[i]  = '0;
         slot_lqi_m[i]  = '0;
         slot_rssi_m[i] = '0;
      end

      // Directed table. Reset settings first: own PAN and short address are zero.
      add_op(OP_DEQUEUE);                                   // dequeue on empty queue
      expect_quiet(4'd8, 1'b0);
      add_frame(0, 7'd20, FT_DATA, AM_SHORT, 1, 8'h01, BCAST_ID, BCAST_ID, '1, 8'd9, 8'd9);
      expect_quiet(4'd8, 1'b0);                             // bad CRC
      add_frame(1, 7'd4, FT_DATA, AM_SHORT, 1, 8'h02, BCAST_ID, BCAST_ID, '1, 8'd9, 8'd9);
      expect_quiet(4'd8, 1'b0);                             // too short
      // broadcast at minimum length; ack request ignored while auto-ack is off
      add_frame(1, 7'd5, FT_DATA, AM_SHORT, 1, 8'h00, BCAST_ID, BCAST_ID, '0, 8'd0, 8'd0);

      add_csr(CSR_AUTO_ACK, 64'd1);
      add_csr(CSR_FILTER_PAN, 64'h1234);
      add_csr(CSR_FILTER_SHORT, 64'hbeef);
      add_csr(CSR_FILTER_LONG, 64'h0123_4567_89ab_cdef);

      // short match at maximum length with extreme LQI and RSSI, ack requested
      add_frame(1, 7'd127, FT_DATA, AM_SHORT, 1, 8'hff, 16'h1234, 16'hbeef, '0,
                8'hff, 8'hff);
      // own PAN with broadcast short address, LQI just below saturation
      add_frame(1, 7'd64, FT_DATA, AM_SHORT, 0, 8'h10, 16'h1234, BCAST_ID, '0,
                8'd63, 8'd128);
      // long address match, LQI just above saturation
      add_frame(1, 7'd20, FT_DATA, AM_LONG, 1, 8'h22, 16'h1234, 16'h0000,
                64'h0123_4567_89ab_cdef, 8'd64, 8'd1);
      // rejects: long mismatch, PAN mismatch, other addressing mode, other frame type
      add_frame(1, 7'd20, FT_DATA, AM_LONG, 1, 8'h23, 16'h1234, 16'h0000,
                64'h0123_4567_89ab_cdee, 8'd10, 8'd10);
      add_frame(1, 7'd20, FT_DATA, AM_SHORT, 1, 8'h24, 16'h1235, 16'hbeef, '0,
                8'd10, 8'd10);
      add_frame(1, 7'd20, FT_DATA, AM_RSVD, 1, 8'h25, 16'h1234, 16'hbeef,
                64'h0123_4567_89ab_cdef, 8'd10, 8'd10);
      add_frame(1, 7'd20, FT_BEACON, AM_SHORT, 1, 8'h26, 16'h1234, 16'hbeef, '0,
                8'd10, 8'd10);
      // ack frame: track its sequence number, store nothing
      add_frame(1, 7'd5, FT_ACK, AM_NONE, 0, 8'ha5, 16'h0000, 16'h0000, '0, 8'd7, 8'd7);
      add_op(OP_DEQUEUE);
      add_op(OP_CLEAR_ACK);

      add_csr(CSR_PROMISCUOUS, 64'd1);

      // promiscuous: store anything, do not track acks, never ack
      add_frame(0, 7'd0, FT_ACK, AM_NONE, 1, 8'h5a, 16'hffff, 16'hffff, '1, 8'd3, 8'd200);
      add_frame(0, 7'd1, FT_RSVD, AM_RSVD, 1, 8'h5b, 16'h0000, 16'h0000, '0, 8'd2, 8'd127);
      add_frame(1, 7'd10, FT_DATA, AM_SHORT, 1, 8'h40, 16'h4321, 16'h1111, '0, 8'd30,
                8'd60, 3);                                  // fill the queue
      add_frame(1, 7'd10, FT_DATA, AM_SHORT, 1, 8'h41, 16'h1234, 16'hbeef, '0, 8'd1, 8'd1);
      expect_quiet(4'd0, 1'b1);                             // queue full
      add_op(OP_DEQUEUE, 5);                                // includes stored lengths 0 and 1
      add_op(OP_FLUSH);
      expect_quiet(4'd8, 1'b0);

      // Hold reset, then release it once.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = $urandom_range(1, 40);

      // Walk the directed table.
      for (i = 0; i < stim_table.size(); i++) begin
         if (stim_table[i].is_csr) begin
            wait_quiet();
            write_csr(stim_table[i].csr_idx, stim_table[i].csr_val);
         end else begin
            repeat (stim_table[i].reps) begin
               send_request(stim_table[i].req, stim_table[i].typed);
               pace_sender();
            end
         end
      end

      // Random phases: drain, rewrite every register, then a run of shaped requests.
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_quiet();
         for (j = 0; j < 5; j++) write_csr(csr_regs[j], pick_setting(csr_widths[j], phase));
         deq_pct = deq_mix[$urandom_range(0, 3)];
         n_items = $urandom_range(60, 160);
         if (n_items > RANDOM_ITEMS - random_sent) n_items = RANDOM_ITEMS - random_sent;
         repeat (n_items) begin
            send_request(random_request(deq_pct), '{default: '0});
            pace_sender();
            random_sent++;
         end
         phase++;
      end

      // Drain the last responses and give the block time to show anything stray.
      wait_quiet();
      if (pending_rsp_q.size() != 0) begin
         $display("%0t: responses never arrived: expected 0 outstanding, actual %0d",
                  $time, pending_rsp_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("** ieee802154_rx_frame_filter_queue_top: PASSED **");
      end else begin
         $display("** ieee802154_rx_frame_filter_queue_top: FAILED **");
      end
      $finish;
   end

endmodule
